/* rtl/quadrature_edge_speed_tracker_macros.svh */
// assertion macros for the quadrature edge speed tracker
// used by the top level only, no other dependencies
`ifndef QUADRATURE_EDGE_SPEED_TRACKER_MACROS_SVH
`define QUADRATURE_EDGE_SPEED_TRACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define QEST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define QEST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qest_pkg.sv */
// shared constants, codes and types of the quadrature edge speed tracker
// no dependencies
package qest_pkg;

  // channel and field sizes
  localparam int NUM_CHANNELS = 2;
  localparam int CH_BITS      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int STAMP_BITS   = 16;
  localparam int PATH_BITS    = 32;
  localparam int SPEED_BITS   = 33;
  localparam int SCALE_BITS   = 32;
  localparam int MS_BITS      = 32;
  localparam int DELAY_BITS   = 16;
  localparam int INV_BITS     = 2;
  localparam int WARM_BITS    = 2;
  localparam int KIND_BITS    = 2;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [WARM_BITS-1:0] WARM_FULL = WARM_BITS'(2);

  // register reset values
  localparam logic [DELAY_BITS-1:0] ZERO_DELAY_RST  = DELAY_BITS'(50);
  localparam logic [SCALE_BITS-1:0] SPEED_SCALE_RST = SCALE_BITS'(804247719);

  // queue between classifier and divider
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // serial divider, one quotient bit per cycle
  localparam int DIV_STEPS    = SCALE_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [KIND_BITS-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ZERO_DELAY  = 2'd0,
    CFG_SPEED_SCALE = 2'd1,
    CFG_INVERT_MASK = 2'd2,
    CFG_SWAP        = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // one classified transaction waiting for the divider
  typedef struct packed {
    logic [PATH_BITS-1:0]  path;
    logic                  speed_valid;
    logic                  back;
    logic [STAMP_BITS-1:0] delta;
    logic [SCALE_BITS-1:0] scale;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/quadrature_edge_speed_tracker.sv */
// top level of the quadrature edge speed tracker
// depends on qest_pkg, qest_front, qest_fifo, qest_back and the assertion macro header

// Two-channel quadrature encoder tracker. Edge transactions update the channel's
// path count, direction, capture stamps and warm-up state; query and clear
// transactions report (and for clear, zero) a channel's path. Every accepted
// transaction yields one result with path, speed, speed-valid and direction.
// The front end takes one transaction per cycle, while the queue is not full,
// into a two-entry queue; the back end computes speed with a serial restoring
// divider, one quotient bit per cycle. A result with valid speed passes from
// the queue through a load, 32 divide steps and the output register; a result
// with invalid speed skips the divider. The back end takes a new entry from the
// queue only after the output register is taken on out_ready_i. Config writes
// are always accepted and are expected only while the block is idle.
module quadrature_edge_speed_tracker
  import qest_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KIND_BITS-1:0]         kind_i,
  input  logic                         channel_sel_i,
  input  logic [STAMP_BITS-1:0]        capture_stamp_i,
  input  logic                         phase_a_i,
  input  logic                         phase_b_i,
  input  logic [MS_BITS-1:0]           now_ms_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [PATH_BITS-1:0]  path_count_o,
  output logic signed [SPEED_BITS-1:0] speed_q16_o,
  output logic                         speed_valid_o,
  output logic                         moving_back_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data_i
);

  logic       push;
  entry_t     push_data;
  logic       pop;
  entry_t     pop_data;
  fifo_stat_t fifo_stat;

  // classifier and channel state
  qest_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .channel_sel_i   (channel_sel_i),
    .capture_stamp_i (capture_stamp_i),
    .phase_a_i       (phase_a_i),
    .phase_b_i       (phase_b_i),
    .now_ms_i        (now_ms_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .fifo_stat_i     (fifo_stat)
  );

  // decoupling queue
  qest_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  // divider and result register
  qest_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .fifo_stat_i   (fifo_stat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .path_count_o  (path_count_o),
    .speed_q16_o   (speed_q16_o),
    .speed_valid_o (speed_valid_o),
    .moving_back_o (moving_back_o)
  );

  // checks
  `include "quadrature_edge_speed_tracker_macros.svh"

  `QEST_ASSERT_NOW(a_invalid_speed_zero, clk_i, rst_ni, out_valid_o && !speed_valid_o, speed_q16_o == '0, "speed nonzero while not valid")
  `QEST_ASSERT_NOW(a_forward_speed_sign, clk_i, rst_ni, out_valid_o && !moving_back_o, !speed_q16_o[SPEED_BITS-1], "forward speed is negative")
  `QEST_ASSERT_NEXT(a_push_lands, clk_i, rst_ni, in_valid_i && in_ready_o, !fifo_stat.empty, "accepted transaction missing from queue")

endmodule

/* rtl/qest_fifo.sv */
// small register queue between the front classifier and the divider back end
// depends on qest_pkg
module qest_fifo
  import qest_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  entry_t     push_data_i,
  input  logic       pop_i,
  output entry_t     pop_data_o,
  output fifo_stat_t stat_o
);

  entry_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] cnt_q, cnt_d;

  // status
  assign stat_o.full  = (cnt_q == FIFO_CNT_BITS'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                 : wr_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ? '0
                 : rd_ptr_q + FIFO_PTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + FIFO_CNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/qest_front.sv */
// front end: config registers, per-channel edge state and transaction classification
// depends on qest_pkg, pushes one entry per accepted transaction into qest_fifo
module qest_front
  import qest_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [KIND_BITS-1:0]     kind_i,
  input  logic                     channel_sel_i,
  input  logic [STAMP_BITS-1:0]    capture_stamp_i,
  input  logic                     phase_a_i,
  input  logic                     phase_b_i,
  input  logic [MS_BITS-1:0]       now_ms_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output logic                     push_o,
  output entry_t                   push_data_o,
  input  fifo_stat_t               fifo_stat_i
);

  // configuration registers
  logic [DELAY_BITS-1:0] zero_delay_q;
  logic [SCALE_BITS-1:0] scale_q;
  logic [INV_BITS-1:0]   invert_q;
  logic                  swap_q;

  // per-channel state
  logic [PATH_BITS-1:0]  path_q [NUM_CHANNELS];
  logic [STAMP_BITS-1:0] prev_q [NUM_CHANNELS];
  logic [STAMP_BITS-1:0] cur_q  [NUM_CHANNELS];
  logic                  back_q [NUM_CHANNELS];
  logic [MS_BITS-1:0]    last_q [NUM_CHANNELS];
  logic [WARM_BITS-1:0]  warm_q [NUM_CHANNELS];

  logic                  accept;
  logic                  is_edge;
  logic                  is_clear;
  logic                  ch_raw;
  logic [CH_BITS-1:0]    ch;
  logic [PATH_BITS-1:0]  path_r;
  logic [STAMP_BITS-1:0] cur_r;
  logic                  back_r;
  logic [MS_BITS-1:0]    last_r;
  logic [WARM_BITS-1:0]  warm_r;
  logic [MS_BITS-1:0]    age;
  logic [WARM_BITS-1:0]  warm_inc;
  logic                  fwd;
  logic [PATH_BITS-1:0]  path_d;
  logic [STAMP_BITS-1:0] prev_d;
  logic [STAMP_BITS-1:0] cur_d;
  logic                  back_d;
  logic [WARM_BITS-1:0]  warm_d;
  logic                  rep_valid;
  logic [STAMP_BITS-1:0] delta_raw;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !fifo_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign push_o      = accept;

  // channel decode: edges address the physical channel, others honor the swap
  assign is_edge  = (kind_i == KIND_EDGE);
  assign is_clear = (kind_i == KIND_CLEAR);
  assign ch_raw   = is_edge ? channel_sel_i : (channel_sel_i ^ swap_q);
  assign ch       = CH_BITS'(int'(ch_raw) % NUM_CHANNELS);

  assign path_r = path_q[ch];
  assign cur_r  = cur_q[ch];
  assign back_r = back_q[ch];
  assign last_r = last_q[ch];
  assign warm_r = warm_q[ch];

  // edge bookkeeping
  assign age      = now_ms_i - last_r;
  assign warm_inc = (warm_r < WARM_FULL) ? warm_r + WARM_BITS'(1) : warm_r;
  assign fwd      = phase_a_i ^ phase_b_i ^ invert_q[ch[0]];

  // post-update channel state for the reported channel
  always_comb begin
    path_d    = path_r;
    prev_d    = prev_q[ch];
    cur_d     = cur_r;
    back_d    = back_r;
    warm_d    = warm_r;
    rep_valid = (warm_r == WARM_FULL) && (age <= MS_BITS'(zero_delay_q));
    if (is_edge) begin
      prev_d    = cur_r;
      cur_d     = capture_stamp_i;
      warm_d    = (age >= MS_BITS'(zero_delay_q)) ? '0 : warm_inc;
      path_d    = fwd ? path_r + PATH_BITS'(1) : path_r - PATH_BITS'(1);
      back_d    = !fwd;
      // the edge time becomes the last edge, so the age reads as zero
      rep_valid = (warm_d == WARM_FULL);
    end else if (is_clear) begin
      path_d = '0;
    end
  end

  // capture delta with wrap, zero taken as one
  always_comb begin
    delta_raw = (cur_d > prev_d) ? cur_d - prev_d : ~(prev_d - cur_d);
    push_data_o.path        = path_d;
    push_data_o.speed_valid = rep_valid;
    push_data_o.back        = back_d;
    push_data_o.delta       = (delta_raw == '0) ? STAMP_BITS'(1) : delta_raw;
    push_data_o.scale       = scale_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_delay_q <= ZERO_DELAY_RST;
      scale_q      <= SPEED_SCALE_RST;
      invert_q     <= '0;
      swap_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ZERO_DELAY:  zero_delay_q <= cfg_data_i[DELAY_BITS-1:0];
        CFG_SPEED_SCALE: scale_q      <= cfg_data_i[SCALE_BITS-1:0];
        CFG_INVERT_MASK: invert_q     <= cfg_data_i[INV_BITS-1:0];
        CFG_SWAP:        swap_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // channel state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        path_q[i] <= '0;
        prev_q[i] <= '0;
        cur_q[i]  <= '0;
        back_q[i] <= 1'b0;
        last_q[i] <= '0;
        warm_q[i] <= '0;
      end
    end else if (accept) begin
      path_q[ch] <= path_d;
      if (is_edge) begin
        prev_q[ch] <= prev_d;
        cur_q[ch]  <= cur_d;
        back_q[ch] <= back_d;
        last_q[ch] <= now_ms_i;
        warm_q[ch] <= warm_d;
      end
    end
  end

endmodule

/* rtl/qest_back.sv */
// back end: serial speed divider and result output register
// depends on qest_pkg, pops entries from qest_fifo
module qest_back
  import qest_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  output logic                         pop_o,
  input  entry_t                       pop_data_i,
  input  fifo_stat_t                   fifo_stat_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [PATH_BITS-1:0]  path_count_o,
  output logic signed [SPEED_BITS-1:0] speed_q16_o,
  output logic                         speed_valid_o,
  output logic                         moving_back_o
);

  back_state_e              state_q, state_d;
  logic [DIV_CNT_BITS-1:0]  cnt_q;
  logic                     last_step;

  logic [PATH_BITS-1:0]     path_q;
  logic                     valid_q;
  logic                     back_q;
  logic [STAMP_BITS-1:0]    dvs_q;
  logic [SCALE_BITS-1:0]    quo_q, quo_d;
  logic [STAMP_BITS-1:0]    rem_q, rem_d;
  logic [SPEED_BITS-1:0]    speed_q, speed_d;

  logic [STAMP_BITS:0]      rem_sh;
  logic                     ge;
  logic [SPEED_BITS-1:0]    quo_ext;

  assign last_step = (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          state_d = pop_data_i.speed_valid ? BK_DIV : BK_DONE;
        end
      end
      BK_DIV: begin
        if (last_step) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o       = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BK_IDLE: pop_o       = !fifo_stat_i.empty;
      BK_DONE: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + DIV_CNT_BITS'(1);
      end
    end
  end

  // restoring divide step, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[SCALE_BITS-1]};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_d   = ge ? STAMP_BITS'(rem_sh - {1'b0, dvs_q}) : rem_sh[STAMP_BITS-1:0];
    quo_d   = {quo_q[SCALE_BITS-2:0], ge};
    quo_ext = {1'b0, quo_d};
    speed_d = back_q ? (~quo_ext + SPEED_BITS'(1)) : quo_ext;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      path_q  <= pop_data_i.path;
      valid_q <= pop_data_i.speed_valid;
      back_q  <= pop_data_i.back;
      dvs_q   <= pop_data_i.delta;
      quo_q   <= pop_data_i.scale;
      rem_q   <= '0;
      speed_q <= '0;
    end else if (state_q == BK_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      if (last_step) begin
        speed_q <= speed_d;
      end
    end
  end

  assign path_count_o  = $signed(path_q);
  assign speed_q16_o   = $signed(speed_q);
  assign speed_valid_o = valid_q;
  assign moving_back_o = back_q;

endmodule
